// ----- hw/rtl/tpi_pkg.sv -----
// tpi_pkg: payload structs, datapath widths and index tables shared by the
// three-plane intersection front end, divider and top level.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;

  typedef struct packed {
    logic signed [31:0] plane1_nx;
    logic signed [31:0] plane1_ny;
    logic signed [31:0] plane1_nz;
    logic signed [31:0] plane1_d;
    logic signed [31:0] plane2_nx;
    logic signed [31:0] plane2_ny;
    logic signed [31:0] plane2_nz;
    logic signed [31:0] plane2_d;
    logic signed [31:0] plane3_nx;
    logic signed [31:0] plane3_ny;
    logic signed [31:0] plane3_nz;
    logic signed [31:0] plane3_d;
  } tpi_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               found;
    logic               overflow;
  } tpi_out_t;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 64;  // one 32x32 product
  localparam int CROSS_W   = 65;  // cross product component
  localparam int SUM_W     = 99;  // det and numerators, signed
  localparam int MAG_W     = 98;  // their magnitudes
  localparam int NTERM     = 12;  // three det terms, nine numerator terms
  localparam int FRONT_LAT = 5;
  localparam int DIV_STEPS = 33;  // range check plus 32 quotient bits
  localparam int THR_W     = 31;

  // cyclic neighbors for cross products
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

endpackage
`default_nettype wire

// ----- hw/rtl/tpi_front.sv -----
// tpi_front: cross products, determinant and numerators, five register stages.
// depends on tpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpi_front (
  input  logic                                clk,
  input  logic                                en,
  input  tpi_pkg::tpi_in_t                    planes,
  output logic signed [tpi_pkg::SUM_W-1:0]    det,
  output logic signed [tpi_pkg::SUM_W-1:0]    num [3]
);
  import tpi_pkg::*;

  logic signed [COORD_W-1:0] n1 [3];
  logic signed [COORD_W-1:0] n2 [3];
  logic signed [COORD_W-1:0] n3 [3];
  logic signed [COORD_W-1:0] dd [3];
  logic signed [COORD_W-1:0] n3_a [3];
  logic signed [COORD_W-1:0] n3_b [3];
  logic signed [COORD_W-1:0] d_a [3];
  logic signed [COORD_W-1:0] d_b [3];
  logic signed [PROD_W-1:0]  pa [9];
  logic signed [PROD_W-1:0]  pb [9];
  logic signed [CROSS_W-1:0] cr [9];
  logic signed [CROSS_W-1:0] ta [NTERM];
  logic signed [COORD_W-1:0] tb [NTERM];
  logic signed [CROSS_W-1:0] ph [NTERM];
  logic signed [CROSS_W-1:0] pl [NTERM];
  logic signed [SUM_W-1:0]   tm [NTERM];

  assign n1[0] = planes.plane1_nx;
  assign n1[1] = planes.plane1_ny;
  assign n1[2] = planes.plane1_nz;
  assign n2[0] = planes.plane2_nx;
  assign n2[1] = planes.plane2_ny;
  assign n2[2] = planes.plane2_nz;
  assign n3[0] = planes.plane3_nx;
  assign n3[1] = planes.plane3_ny;
  assign n3[2] = planes.plane3_nz;
  assign dd[0] = planes.plane1_d;
  assign dd[1] = planes.plane2_d;
  assign dd[2] = planes.plane3_d;

  // products: rows are n1 x n2, n3 x n2, n1 x n3
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa[i]   <= n1[NXT1[i]] * n2[NXT2[i]];
        pb[i]   <= n1[NXT2[i]] * n2[NXT1[i]];
        pa[3+i] <= n3[NXT1[i]] * n2[NXT2[i]];
        pb[3+i] <= n3[NXT2[i]] * n2[NXT1[i]];
        pa[6+i] <= n1[NXT1[i]] * n3[NXT2[i]];
        pb[6+i] <= n1[NXT2[i]] * n3[NXT1[i]];
        n3_a[i] <= n3[i];
        d_a[i]  <= dd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int x = 0; x < 9; x++) begin
        cr[x] <= CROSS_W'(pa[x]) - CROSS_W'(pb[x]);
      end
      for (int i = 0; i < 3; i++) begin
        n3_b[i] <= n3_a[i];
        d_b[i]  <= d_a[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta[i]       = cr[i];
      tb[i]       = n3_b[i];
      ta[3+3*i]   = cr[3+i];
      tb[3+3*i]   = d_b[0];
      ta[4+3*i]   = cr[6+i];
      tb[4+3*i]   = d_b[1];
      ta[5+3*i]   = cr[i];
      tb[5+3*i]   = d_b[2];
    end
  end

  // 65x32 split into signed high and unsigned low halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NTERM; t++) begin
        ph[t] <= $signed(ta[t][CROSS_W-1:32]) * tb[t];
        pl[t] <= $signed({1'b0, ta[t][31:0]}) * tb[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NTERM; t++) begin
        tm[t] <= (SUM_W'(ph[t]) <<< 32) + SUM_W'(pl[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= tm[0] + tm[1] + tm[2];
      for (int i = 0; i < 3; i++) begin
        num[i] <= tm[3+3*i] + tm[4+3*i] - tm[5+3*i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tpi_div.sv -----
// tpi_div: pipelined restoring divider, a range-check stage then one quotient bit per
// stage, with saturation of the signed 32-bit result. depends on tpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [tpi_pkg::MAG_W+FRAC_BITS-1:0]      dividend,
  input  logic [tpi_pkg::MAG_W-1:0]                divisor,
  input  logic                                     neg,
  output logic signed [tpi_pkg::COORD_W-1:0]       value,
  output logic                                     ovf
);
  import tpi_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int SW = MAG_W + DIV_STEPS;
  localparam int CW = (NW > SW) ? NW : SW;

  logic [CW-1:0]      rem [DIV_STEPS+1];
  logic [MAG_W-1:0]   dvs [DIV_STEPS+1];
  logic [COORD_W-1:0] quo [DIV_STEPS+1];
  logic               big [DIV_STEPS+1];
  logic               sgn [DIV_STEPS+1];
  logic [COORD_W-1:0] lim;
  logic [COORD_W-1:0] qf;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(dividend);
      dvs[0] <= divisor;
      quo[0] <= '0;
      big[0] <= 1'b0;
      sgn[0] <= neg;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - s;
    logic [CW-1:0] sub_v;
    logic          ge;
    assign sub_v = CW'(dvs[s]) << SH;
    assign ge    = rem[s] >= sub_v;
    if (s == 0) begin : g_range
      // quotient of 2^32 or more saturates no matter the low bits
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= rem[s];
          dvs[s+1] <= dvs[s];
          quo[s+1] <= quo[s];
          big[s+1] <= ge;
          sgn[s+1] <= sgn[s];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= ge ? rem[s] - sub_v : rem[s];
          dvs[s+1] <= dvs[s];
          quo[s+1] <= quo[s] | (ge ? (COORD_W'(1) << SH) : '0);
          big[s+1] <= big[s];
          sgn[s+1] <= sgn[s];
        end
      end
    end
  end

  assign qf  = quo[DIV_STEPS];
  assign lim = sgn[DIV_STEPS] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  assign ovf = big[DIV_STEPS] || (qf > lim);

  always_comb begin
    if (ovf) begin
      value = $signed(lim);
    end else if (sgn[DIV_STEPS]) begin
      value = $signed(-qf);
    end else begin
      value = $signed(qf);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/three_plane_intersection.sv -----
// three_plane_intersection: top level, input register, threshold register,
// sign/magnitude stage and output register. depends on tpi_pkg, tpi_front, tpi_div.
//
// channel   dir  handshake               payload
// query     in   query_valid/query_stall  tpi_in_t, three planes
// result    out  result_valid/result_stall tpi_out_t, point and flags
// cfg       in   cfg_valid/cfg_ready      det_threshold, 31 bits
//
// one item accepted per cycle unless stalled; the result passes through 41 registers,
// the first loaded at acceptance: input register, five front-end stages, one sign
// stage, 33 divider stages, output register.
// reset clears all valid bits and sets det_threshold to 1.
// a stalled result freezes the whole pipeline; the input stalls in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module three_plane_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         query_valid,
  output logic                         query_stall,
  input  tpi_pkg::tpi_in_t             query,
  output logic                         result_valid,
  input  logic                         result_stall,
  output tpi_pkg::tpi_out_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpi_pkg::THR_W-1:0]    cfg_data
);
  import tpi_pkg::*;

  localparam int NW   = MAG_W + FRAC_BITS;
  localparam int NSTG = 1 + FRONT_LAT + 1 + DIV_STEPS;

  logic               en;
  logic [THR_W-1:0]   det_threshold;
  logic               vld [NSTG];
  logic               fnd [DIV_STEPS+1];
  tpi_in_t            q_reg;
  logic signed [SUM_W-1:0] det;
  logic signed [SUM_W-1:0] num [3];
  logic [SUM_W-1:0]   det_abs_w;
  logic [MAG_W-1:0]   det_abs;
  logic [MAG_W-1:0]   thr_wide;
  logic               found_now;
  logic [SUM_W-1:0]   num_abs_w [3];
  logic [NW-1:0]      dvd [3];
  logic               neg [3];
  logic signed [COORD_W-1:0] val [3];
  logic               ovf [3];

  assign en          = !(result_valid && result_stall);
  assign query_stall = !en;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      det_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= query_valid;
      for (int k = 1; k < NSTG; k++) vld[k] <= vld[k-1];
      result_valid <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_reg <= query;
    end
  end

  tpi_front u_front (
    .clk    (clk),
    .en     (en),
    .planes (q_reg),
    .det    (det),
    .num    (num)
  );

  // magnitudes, signs and the threshold test
  assign det_abs_w = det[SUM_W-1] ? -det : det;
  assign det_abs   = det_abs_w[MAG_W-1:0];
  assign thr_wide  = MAG_W'(det_threshold) << (2 * FRAC_BITS);
  assign found_now = det_abs > thr_wide;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_abs_w[i] = num[i][SUM_W-1] ? -num[i] : num[i];
      dvd[i]       = NW'(num_abs_w[i][MAG_W-1:0]) << FRAC_BITS;
      neg[i]       = num[i][SUM_W-1] ^ det[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fnd[0] <= found_now;
      for (int k = 1; k <= DIV_STEPS; k++) fnd[k] <= fnd[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    tpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .en       (en),
      .dividend (dvd[i]),
      .divisor  (det_abs),
      .neg      (neg[i]),
      .value    (val[i]),
      .ovf      (ovf[i])
    );
  end

  // no intersection reports zeros and clear flags
  always_ff @(posedge clk) begin
    if (en) begin
      result.point_x  <= fnd[DIV_STEPS] ? val[0] : '0;
      result.point_y  <= fnd[DIV_STEPS] ? val[1] : '0;
      result.point_z  <= fnd[DIV_STEPS] ? val[2] : '0;
      result.found    <= fnd[DIV_STEPS];
      result.overflow <= fnd[DIV_STEPS] && (ovf[0] || ovf[1] || ovf[2]);
    end
  end

endmodule
`default_nettype wire
